// ----- design/utx_pkg.sv -----
// Shared types, constants and CRC step function for the UART transmitter with CRC-32.
`default_nettype none

package utx_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned CrcW    = 32;
  localparam int unsigned FrameW  = 10;
  localparam int unsigned CntW    = $clog2(FrameW);
  localparam int unsigned InDataW = 48;   // 42 payload bits padded to whole bytes
  localparam int unsigned OutDataW = 40;  // 33 payload bits padded to whole bytes

  localparam logic [CrcW-1:0]  CrcPoly  = 32'hEDB8_8320;
  localparam logic [CntW-1:0]  StopBit  = CntW'(FrameW - 1);

  // One byte waiting for the serializer, with the CRC reported on its bits.
  typedef struct packed {
    logic [DataW-1:0] data;
    logic [CrcW-1:0]  crc;
    logic             last;
  } utx_item_t;

  // Reflected CRC-32 over one byte, LSB first, no final inversion.
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc_in,
                                               input logic [DataW-1:0] byte_in);
    logic [CrcW-1:0] c;
    c = crc_in ^ {{(CrcW-DataW){1'b0}}, byte_in};
    for (int k = 0; k < DataW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/utx_ser.sv -----
// Frame serializer: turns one queued byte into ten 8N1 bit-time transactions.
`default_nettype none

module utx_ser (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         item_valid,
  output logic                        item_ready,
  input  wire  utx_pkg::utx_item_t    item,
  output logic                        m_tvalid,
  input  wire                         m_tready,
  output logic [utx_pkg::OutDataW-1:0] m_tdata,  // [0] line_level, [32:1] crc_value, pad
  output logic                        m_tlast,   // frame_last
  output logic                        m_tuser    // crc_final
);
  import utx_pkg::*;

  logic              busy;
  logic [CntW-1:0]   cnt;
  logic [FrameW-1:0] frame;
  logic [CrcW-1:0]   crc;
  logic              last;

  logic out_fire;
  logic at_stop;

  assign out_fire   = busy && m_tready;
  assign at_stop    = (cnt == StopBit);
  assign item_ready = !busy || (m_tready && at_stop);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (item_valid && item_ready) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (out_fire) begin
      if (at_stop) begin
        busy <= 1'b0;
        cnt  <= '0;
      end else begin
        cnt <= cnt + CntW'(1);
      end
    end
  end

  // Payload: load stop, data and start bits; shift right per bit time.
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      frame <= {1'b1, item.data, 1'b0};
      crc   <= item.crc;
      last  <= item.last;
    end else if (out_fire) begin
      frame <= {1'b1, frame[FrameW-1:1]};
    end
  end

  assign m_tvalid = busy;
  assign m_tdata  = {{(OutDataW-CrcW-1){1'b0}}, crc, frame[0]};
  assign m_tlast  = at_stop;
  assign m_tuser  = at_stop && last;

endmodule

`default_nettype wire

// ----- design/uart_tx_with_crc32.sv -----
// Top level: 8N1 UART transmitter stream with a running reflected CRC-32.
// Path: an accepted byte passes the input register, then the frame register, before its
//   start bit is offered; a busy serializer holds it in the input register.
// Each byte gives ten output transactions, counted by the serializer's bit counter; the
//   next byte loads as the stop bit is taken, so frames can run back to back.
// Reset: synchronous, active high; clears the running CRC and both valid flags.
`default_nettype none

module uart_tx_with_crc32 (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            s_tvalid,
  output logic                           s_tready,
  input  wire  [utx_pkg::InDataW-1:0]    s_tdata,  // [7:0] data_byte, [8] crc_enable,
                                                   // [9] crc_load, [41:10] crc_seed, pad
  input  wire                            s_tlast,  // last_byte
  output logic                           m_tvalid,
  input  wire                            m_tready,
  output logic [utx_pkg::OutDataW-1:0]   m_tdata,  // [0] line_level, [32:1] crc_value, pad
  output logic                           m_tlast,  // frame_last
  output logic                           m_tuser   // crc_final
);
  import utx_pkg::*;

  // Unpack the slave-side transaction.
  logic [DataW-1:0] in_data;
  logic             in_enable;
  logic             in_load;
  logic [CrcW-1:0]  in_seed;

  assign in_data   = s_tdata[DataW-1:0];
  assign in_enable = s_tdata[DataW];
  assign in_load   = s_tdata[DataW+1];
  assign in_seed   = s_tdata[DataW+2 +: CrcW];

  // Running CRC state; updated as each byte is accepted so the next byte sees it.
  logic [CrcW-1:0] crc_running;
  logic [CrcW-1:0] crc_base;
  logic [CrcW-1:0] crc_running_next;

  // Input register: one byte held while the serializer finishes the previous frame.
  logic       pend_valid;
  utx_item_t  pend;
  logic       ser_ready;
  logic       s_fire;

  assign s_tready = !pend_valid || ser_ready;
  assign s_fire   = s_tvalid && s_tready;

  // Seed load only counts when the CRC is enabled for this byte.
  always_comb begin
    crc_base         = in_load ? in_seed : crc_running;
    crc_running_next = in_enable ? crc_byte(crc_base, in_data) : crc_running;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_running <= '0;
      pend_valid  <= 1'b0;
    end else begin
      if (s_fire) begin
        crc_running <= crc_running_next;
        pend_valid  <= 1'b1;
      end else if (ser_ready) begin
        pend_valid  <= 1'b0;
      end
    end
  end

  // Payload: capture the byte together with the CRC it reports.
  always_ff @(posedge clk) begin
    if (s_fire) begin
      pend.data <= in_data;
      pend.crc  <= crc_running_next;
      pend.last <= s_tlast;
    end
  end

  // Serializer: start bit, eight data bits LSB first, stop bit.
  utx_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (pend_valid),
    .item_ready (ser_ready),
    .item       (pend),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

  // The stop bit of every frame drives the line high.
  assert property (@(posedge clk) disable iff (rst) (m_tvalid && m_tlast) |-> m_tdata[0])
    else $error("stop bit not high");

  // A final-CRC flag only appears on the stop bit.
  assert property (@(posedge clk) disable iff (rst) (m_tvalid && m_tuser) |-> m_tlast)
    else $error("crc_final outside stop bit");

  // The running CRC holds between accepted bytes.
  assert property (@(posedge clk) disable iff (rst) !s_fire |=> $stable(crc_running))
    else $error("crc changed without a byte");

  // After a stop bit is taken, the next bit offered is a start bit (low).
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || !m_tdata[0]))
    else $error("frame does not open with a start bit");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the 8N1 UART transmitter stream with running CRC-32.
`timescale 1ns / 100ps

module tb_top;

  import utx_pkg::InDataW;
  import utx_pkg::OutDataW;

  localparam int          ClkPeriod     = 10;
  localparam int          FrameBits     = 10;
  localparam logic [31:0] Crc32Poly     = 32'hEDB8_8320;
  localparam int          RandomItems   = 85;
  localparam int          HoldOffCycles = 300;
  localparam int          DrainSettle   = 6;     // a little over the input-to-output latency
  localparam int          TimeoutNs     = 3_000_000;

  // One serial bit time as the block should present it on the master side.
  typedef struct {
    logic        line_level;
    logic        frame_last;
    logic [31:0] crc_value;
    logic        crc_final;
  } line_bit_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata  = '0;   // [7:0] data_byte, [8] crc_enable, [9] crc_load,
                                        // [41:10] crc_seed, zero pad
  logic                s_tlast  = 1'b0; // last_byte
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;         // [0] line_level, [32:1] crc_value, zero pad
  logic                m_tlast;         // frame_last
  logic                m_tuser;         // crc_final

  // Golden copy of the running CRC and the queue of line bits still owed by the block.
  logic [31:0] crc_shadow = '0;
  line_bit_t   line_bits_due[$];
  int          mismatch_count = 0;
  int          bits_seen = 0;

  // Sender burst control and the receiver hold-off request.
  bit gaps_on      = 1'b1;
  int burst_left   = 0;
  bit hold_off_req = 1'b0;

  uart_tx_with_crc32 u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin : clock_gen
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Reflected CRC-32, one data bit per step: feed back bit 0 xor the next data bit.
  function automatic logic [31:0] crc32_advance(input logic [31:0] crc_in,
                                                input logic [7:0]  data_in);
    logic [31:0] acc;
    logic        fb;
    acc = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ data_in[i];
      acc = acc >> 1;
      if (fb) begin
        acc = acc ^ Crc32Poly;
      end
    end
    return acc;
  endfunction

  // Advance the CRC shadow for one accepted byte and queue the ten line bits it causes.
  function automatic void predict_frame(input logic [7:0]  data_byte,
                                        input logic        crc_enable,
                                        input logic        crc_load,
                                        input logic [31:0] crc_seed,
                                        input logic        last_byte);
    logic [9:0] frame;
    line_bit_t  lb;
    // A load only counts when the CRC is enabled; otherwise the shadow holds.
    if (crc_enable) begin
      if (crc_load) begin
        crc_shadow = crc_seed;
      end
      crc_shadow = crc32_advance(crc_shadow, data_byte);
    end
    // Start bit low, data LSB first, stop bit high.
    frame = {1'b1, data_byte, 1'b0};
    for (int k = 0; k < FrameBits; k++) begin
      lb.line_level = frame[k];
      lb.frame_last = (k == FrameBits - 1);
      lb.crc_value  = crc_shadow;
      lb.crc_final  = (k == FrameBits - 1) && last_byte;
      line_bits_due.push_back(lb);
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH bit %0d: %s", $time, bits_seen, what);
    mismatch_count++;
  endtask

  // Offer one byte on the slave side and wait for its transaction.
  // Leave tvalid high on return so a following byte can go out back to back.
  task automatic send_byte(input logic [7:0]  data_byte,
                           input logic        crc_enable,
                           input logic        crc_load,
                           input logic [31:0] crc_seed,
                           input logic        last_byte);
    // Insert an idle gap between bursts when gaps are on.
    if (gaps_on && burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(InDataW - 42){1'b0}}, crc_seed, crc_load, crc_enable, data_byte};
    s_tlast  <= last_byte;
    do begin
      @(posedge clk);
    end while (!s_tready);
    predict_frame(data_byte, crc_enable, crc_load, crc_seed, last_byte);
  endtask

  // Drop tvalid, then wait for every owed line bit plus the DrainSettle slack.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (line_bits_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainSettle) @(posedge clk);
  endtask

  // Receiver: change ready behavior at random intervals; honor a long hold-off on request.
  initial begin : rx_ready_pattern
    int mode;
    int mode_left;
    int phase;
    mode      = 0;
    mode_left = 0;
    phase     = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        phase++;
        case (mode)
          0: begin
            m_tready <= 1'b1;
          end
          1: begin
            m_tready <= ($urandom_range(0, 3) != 0);
          end
          2: begin
            m_tready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            // Periodic stall that slides across the ten bit phases of a frame.
            m_tready <= (phase % 7) != 0;
          end
        endcase
      end
    end
  end

  // Check every master-side transaction against the oldest owed line bit.
  always @(posedge clk) begin : check_line_bits
    line_bit_t exp_bit;
    if (!rst && m_tvalid && m_tready) begin
      if (line_bits_due.size() == 0) begin
        report_mismatch("transaction with nothing expected");
      end else begin
        exp_bit = line_bits_due.pop_front();
        if (m_tdata[0] !== exp_bit.line_level) begin
          report_mismatch($sformatf("line_level %b, expected %b",
                                    m_tdata[0], exp_bit.line_level));
        end
        if (m_tlast !== exp_bit.frame_last) begin
          report_mismatch($sformatf("frame_last %b, expected %b",
                                    m_tlast, exp_bit.frame_last));
        end
        if (m_tdata[32:1] !== exp_bit.crc_value) begin
          report_mismatch($sformatf("crc_value %h, expected %h",
                                    m_tdata[32:1], exp_bit.crc_value));
        end
        if (m_tuser !== exp_bit.crc_final) begin
          report_mismatch($sformatf("crc_final %b, expected %b",
                                    m_tuser, exp_bit.crc_final));
        end
      end
      bits_seen++;
    end
  end

  // Framing with the CRC off: all-zero, all-one and alternating bytes, single end bits.
  task automatic test_frame_extremes();
    gaps_on = 1'b0;
    send_byte(8'h00, 1'b0, 1'b0, 32'h0000_0000, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1);
    send_byte(8'h55, 1'b0, 1'b0, 32'h5555_5555, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b0, 32'hAAAA_AAAA, 1'b1);
    send_byte(8'h01, 1'b0, 1'b0, 32'h0000_0001, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0, 32'h8000_0000, 1'b0);
    wait_drained();
  endtask

  // Seeded writes: all-ones, zero and arbitrary seeds, with updates without a reload between them.
  task automatic test_crc_seed_and_update();
    gaps_on = 1'b1;
    send_byte(8'h31, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
    send_byte(8'h32, 1'b1, 1'b0, 32'h0000_0000, 1'b0);
    send_byte(8'h33, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1, 32'h0000_0000, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0, 32'h1234_5678, 1'b0);
    send_byte(8'hA5, 1'b1, 1'b1, 32'hDEAD_BEEF, 1'b1);
    wait_drained();
  endtask

  // Load without enable must not touch the CRC; disabled bytes report it unchanged;
  // the final flag still follows the end-of-write marker with the CRC off.
  task automatic test_crc_special_cases();
    gaps_on = 1'b0;
    send_byte(8'h5A, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0);
    send_byte(8'hC3, 1'b0, 1'b0, 32'h0BAD_F00D, 1'b0);
    send_byte(8'h7E, 1'b0, 1'b0, 32'h0000_0000, 1'b1);
    send_byte(8'h81, 1'b0, 1'b1, 32'h0000_0000, 1'b1);
    send_byte(8'h3C, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0);
    wait_drained();
  endtask

  // Hold the receiver off for a long stretch while bytes keep coming, so the
  // block fills and stalls its input; then let everything drain.
  task automatic test_output_backpressure();
    gaps_on      = 1'b0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_byte(8'($urandom), 1'b1, (i == 0), $urandom, (i == 5));
    end
    while (hold_off_req) begin
      @(posedge clk);
    end
    wait_drained();
  endtask

  // Mostly well-formed writes (load on the first byte, last on the final one)
  // with random content, mixed with noise bytes and broken writes.
  task automatic test_random_writes();
    int          sent;
    int          len;
    int          pick;
    bit          paused;
    logic [31:0] seed;
    sent   = 0;
    paused = 1'b0;
    while (sent < RandomItems) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 9);
      if (pick < 2) begin
        // Noise: every field random.
        send_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  $urandom, 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        len = $urandom_range(1, 8);
        case ($urandom_range(0, 3))
          0:       seed = 32'hFFFF_FFFF;
          1:       seed = 32'h0000_0000;
          default: seed = $urandom;
        endcase
        for (int i = 0; i < len; i++) begin
          if (pick == 9) begin
            // Broken write: drop the CRC enable or the end marker at random.
            send_byte(8'($urandom), 1'($urandom_range(0, 1)), (i == 0),
                      (i == 0) ? seed : $urandom,
                      (i == len - 1) && $urandom_range(0, 1));
          end else begin
            send_byte(8'($urandom), 1'b1, (i == 0), (i == 0) ? seed : $urandom,
                      (i == len - 1));
          end
          sent++;
        end
      end
      // Pause the sender once until every owed bit is out.
      if (!paused && sent >= RandomItems / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    wait_drained();
  endtask

  initial begin : main_sequence
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_frame_extremes();
    test_crc_seed_and_update();
    test_crc_special_cases();
    test_output_backpressure();
    test_random_writes();
    if (mismatch_count == 0 && line_bits_due.size() == 0) begin
      $display("** uart_tx_with_crc32: PASSED **");
    end else begin
      $display("** uart_tx_with_crc32: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("[%0t] timeout with %0d bits outstanding", $time, line_bits_due.size());
    $display("** uart_tx_with_crc32: FAILED **");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/utx_pkg.sv
design/utx_ser.sv
design/uart_tx_with_crc32.sv
tb/tb_top.sv
